FILE: hdl/substring_first_match_defines.svh
// assertion macros used by the substring search back end
`ifndef SUBSTRING_FIRST_MATCH_DEFINES_SVH
`define SUBSTRING_FIRST_MATCH_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SFM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sfm_pkg.sv
// types and constants of the substring search block
`default_nettype none

package sfm_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TEXT   = 2'd2;
  localparam logic [1:0] OP_END    = 2'd3;

  localparam int MAX_PATTERN_LIMIT = 64;
  localparam int LEN_W   = $clog2(MAX_PATTERN_LIMIT + 1);
  localparam int COUNT_W = 17;
  localparam int START_W = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_in;
  } item_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] match_start;
  } result_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_APPEND,
    CMD_TEXT,
    CMD_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       ch;
    logic [LEN_W-1:0] len;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/sfm_front.sv
// front end: accepts items, tracks pattern length and issues commands
`default_nettype none

module sfm_front #(
  parameter int MAX_PATTERN = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_stall,
  input  wire sfm_pkg::item_t item,
  input  wire logic          full,
  output logic               push,
  output sfm_pkg::cmd_t      push_cmd
);

  localparam int LW = $clog2(MAX_PATTERN + 1);

  logic [LW-1:0] pat_len;
  logic [LW-1:0] pat_len_next;
  logic          accept;

  assign item_stall = full;
  assign accept     = item_valid && !full;

  always_comb begin
    pat_len_next  = pat_len;
    push          = 1'b0;
    push_cmd.kind = sfm_pkg::CMD_TEXT;
    push_cmd.ch   = item.char_in;
    push_cmd.len  = sfm_pkg::LEN_W'(pat_len);
    if (accept) begin
      case (item.opcode)
        sfm_pkg::OP_CLEAR: begin
          push          = 1'b1;
          push_cmd.kind = sfm_pkg::CMD_CLEAR;
          pat_len_next  = '0;
        end
        sfm_pkg::OP_APPEND: begin
          // bytes beyond a full pattern are dropped here
          if (pat_len < LW'(MAX_PATTERN)) begin
            push          = 1'b1;
            push_cmd.kind = sfm_pkg::CMD_APPEND;
            pat_len_next  = pat_len + 1'b1;
          end
        end
        sfm_pkg::OP_TEXT: begin
          push          = 1'b1;
          push_cmd.kind = sfm_pkg::CMD_TEXT;
        end
        default: begin
          push          = 1'b1;
          push_cmd.kind = sfm_pkg::CMD_END;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len <= '0;
    end else begin
      pat_len <= pat_len_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sfm_queue.sv
// command queue between front and back end
`default_nettype none

module sfm_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire sfm_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output sfm_pkg::cmd_t      pop_cmd,
  output logic               empty
);

  sfm_pkg::cmd_t                entries [sfm_pkg::QUEUE_DEPTH];
  logic [sfm_pkg::QPTR_W-1:0]   wr_ptr;
  logic [sfm_pkg::QPTR_W-1:0]   rd_ptr;
  logic [sfm_pkg::QCNT_W-1:0]   fill;

  assign full    = (fill == sfm_pkg::QCNT_W'(sfm_pkg::QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sfm_back.sv
// back end: pattern store, text window, parallel compare and result register
`default_nettype none
`include "substring_first_match_defines.svh"

module sfm_back #(
  parameter int MAX_PATTERN = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          empty,
  input  wire sfm_pkg::cmd_t pop_cmd,
  output logic               pop,
  output logic               result_valid,
  input  wire logic          result_stall,
  output sfm_pkg::result_t   result
);

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [sfm_pkg::COUNT_W-1:0] COUNT_MAX = '1;

  logic [7:0]                   pattern    [MAX_PATTERN];
  logic [7:0]                   window     [MAX_PATTERN];
  logic [7:0]                   window_new [MAX_PATTERN];
  logic [sfm_pkg::COUNT_W-1:0]  text_count;
  logic [sfm_pkg::COUNT_W-1:0]  count_next;
  logic [sfm_pkg::COUNT_W-1:0]  start_raw;
  logic                         seen;
  logic [sfm_pkg::START_W-1:0]  first_start;
  logic [LW-1:0]                len;
  logic [MAX_PATTERN-1:0]       eq;
  logic                         hit;
  logic                         out_free;

  assign len      = pop_cmd.len[LW-1:0];
  assign out_free = !result_valid || !result_stall;
  assign pop      = !empty && ((pop_cmd.kind != sfm_pkg::CMD_END) || out_free);

  always_comb begin
    window_new[0] = pop_cmd.ch;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      window_new[i] = window[i-1];
    end
  end

  // pattern byte j against the byte len-1-j places behind the newest
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cmp
    logic [LW-1:0] idx;
    assign idx   = len - LW'(j) - 1'b1;
    assign eq[j] = (LW'(j) >= len) || (pattern[j] == window_new[idx[IW-1:0]]);
  end

  assign count_next = (text_count == COUNT_MAX) ? text_count : text_count + 1'b1;
  assign start_raw  = count_next - sfm_pkg::COUNT_W'(len);
  assign hit        = !seen && (len != '0) && (count_next >= sfm_pkg::COUNT_W'(len)) && (&eq);

  always_ff @(posedge clk) begin
    if (rst) begin
      text_count   <= '0;
      seen         <= 1'b0;
      first_start  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (pop && (pop_cmd.kind == sfm_pkg::CMD_END)) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (pop) begin
        case (pop_cmd.kind)
          sfm_pkg::CMD_CLEAR, sfm_pkg::CMD_END: begin
            text_count  <= '0;
            seen        <= 1'b0;
            first_start <= '0;
          end
          sfm_pkg::CMD_TEXT: begin
            text_count <= count_next;
            if (hit) begin
              seen <= 1'b1;
              // saturate start index
              first_start <= start_raw[sfm_pkg::COUNT_W-1] ? '1
                           : start_raw[sfm_pkg::START_W-1:0];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      case (pop_cmd.kind)
        sfm_pkg::CMD_APPEND: begin
          pattern[len[IW-1:0]] <= pop_cmd.ch;
        end
        sfm_pkg::CMD_TEXT: begin
          window <= window_new;
        end
        sfm_pkg::CMD_END: begin
          result.found       <= (len == '0) ? (text_count != '0) : seen;
          result.match_start <= (len == '0) ? '0 : first_start;
        end
        default: begin
        end
      endcase
    end
  end

  `SFM_ASSERT_IMP(a_end_needs_room, clk, rst, pop && (pop_cmd.kind == sfm_pkg::CMD_END), out_free, "end transaction taken while result register busy")
  `SFM_ASSERT_IMP(a_start_zero_unseen, clk, rst, !seen, first_start == '0, "start index set without a match")
  `SFM_ASSERT_IMP(a_seen_drop, clk, rst, $fell(seen), $past(rst) || $past(pop && ((pop_cmd.kind == sfm_pkg::CMD_CLEAR) || (pop_cmd.kind == sfm_pkg::CMD_END))), "match latch lost without clear or end")

endmodule

`default_nettype wire

FILE: hdl/substring_first_match.sv
// Substring search: finds the first occurrence of a pattern of up to MAX_PATTERN bytes in a
// byte stream. Clear, append, text and end transactions are accepted at one per clock
// until the queue fills; the front end tracks pattern length and drops bytes beyond a full
// pattern, a four-entry command queue decouples it from the back end, and the back end
// executes one command per cycle, comparing every text byte against the whole pattern in
// parallel. An end transaction passes through the queue and then the result register; it
// waits in the queue only while the result register holds an untaken result, and input
// stalls once the queue fills. No clearing pass is needed after reset.
`default_nettype none

module substring_first_match #(
  parameter int MAX_PATTERN = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire sfm_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output sfm_pkg::result_t      result
);

  logic          push;
  logic          full;
  logic          pop;
  logic          empty;
  sfm_pkg::cmd_t push_cmd;
  sfm_pkg::cmd_t pop_cmd;

  sfm_front #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .full      (full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  sfm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (full),
    .pop     (pop),
    .pop_cmd (pop_cmd),
    .empty   (empty)
  );

  sfm_back #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (empty),
    .pop_cmd     (pop_cmd),
    .pop         (pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// self-checking testbench of the substring first-match search block
`timescale 1ns / 100ps

module testbench;
  import sfm_pkg::*;

  localparam int PATTERN_MAX = 16;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    item_t   it;
    int      reps;
    bit      typed;
    result_t want;
  } plan_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  // search state as the block should hold it
  logic [7:0]  pat_bytes [PATTERN_MAX];
  int unsigned pat_len = 0;
  logic [7:0]  window [PATTERN_MAX];
  logic [16:0] text_seen = '0;
  logic        match_latched = 1'b0;
  logic [15:0] first_at = '0;

  result_t pending_reports [$];
  int errors = 0;
  int ends_issued = 0;
  int useful_items = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_token = 0;

  plan_row_t plan [29] = '{
    '{'{OP_END,    8'h00}, 1,      1'b1, '{1'b0, 16'h0000}},
    '{'{OP_TEXT,   8'h00}, 1,      1'b0, '{1'b0, 16'h0000}},
    '{'{OP_END,    8'hFF}, 1,      1'b1, '{1'b1, 16'h0000}},
    '{'{OP_APPEND, 8'hFF}, 1,      1'b0, '{1'b0, 16'h0000}},
    '{'{OP_APPEND, 8'h00}, 1,      1'b0, '{1'b0, 16'h0000}},
    '{'{OP_TEXT,   8'hFF}, 1,      1'b0, '{1'b0, 16'h0000}},
    '{'{OP_END,    8'h00}, 1,      1'b1, '{1'b0, 16'h0000}},
    '{'{OP_TEXT,   8'h00}, 1,      1'b0, '{1'b0, 16'h0000}},
    '{'{OP_TEXT,   8'hFF}, 1,      1'b0, '{1'b0, 16'h0000}},
    '{'{OP_TEXT,   8'h00}, 1,      1'b0, '{1'b0, 16'h0000}},
    '{'{OP_END,    8'h00}, 1,      1'b1, '{1'b1, 16'h0001}},
    // pattern grows while text is arriving
    '{'{OP_TEXT,   8'hFF}, 1,      1'b0, '{1'b0, 16'h0000}},
    '{'{OP_APPEND, 8'h55}, 1,      1'b0, '{1'b0, 16'h0000}},
    '{'{OP_TEXT,   8'h00}, 1,      1'b0, '{1'b0, 16'h0000}},
    '{'{OP_TEXT,   8'h55}, 1,      1'b0, '{1'b0, 16'h0000}},
    '{'{OP_END,    8'h00}, 1,      1'b0, '{1'b0, 16'h0000}},
    '{'{OP_TEXT,   8'h55}, 3,      1'b0, '{1'b0, 16'h0000}},
    '{'{OP_CLEAR,  8'hFF}, 1,      1'b0, '{1'b0, 16'h0000}},
    '{'{OP_END,    8'h00}, 1,      1'b1, '{1'b0, 16'h0000}},
    // full pattern, surplus bytes dropped
    '{'{OP_APPEND, 8'hA5}, 20,     1'b0, '{1'b0, 16'h0000}},
    '{'{OP_TEXT,   8'hA5}, 15,     1'b0, '{1'b0, 16'h0000}},
    '{'{OP_END,    8'h00}, 1,      1'b0, '{1'b0, 16'h0000}},
    '{'{OP_TEXT,   8'hA5}, 17,     1'b0, '{1'b0, 16'h0000}},
    '{'{OP_END,    8'h00}, 1,      1'b0, '{1'b0, 16'h0000}},
    // single-byte pattern found late in the text
    '{'{OP_CLEAR,  8'h00}, 1,      1'b0, '{1'b0, 16'h0000}},
    '{'{OP_APPEND, 8'h3C}, 1,      1'b0, '{1'b0, 16'h0000}},
    '{'{OP_TEXT,   8'h00}, 20,     1'b0, '{1'b0, 16'h0000}},
    '{'{OP_TEXT,   8'h3C}, 1,      1'b0, '{1'b0, 16'h0000}},
    '{'{OP_END,    8'h00}, 1,      1'b0, '{1'b0, 16'h0000}}
  };

  substring_first_match #(.MAX_PATTERN(PATTERN_MAX)) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic item_t mk(logic [1:0] op, logic [7:0] ch);
    item_t it;
    it.opcode = op;
    it.char_in = ch;
    return it;
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  function automatic void forget_text();
    foreach (window[i]) window[i] = 8'h00;
    text_seen = '0;
    match_latched = 1'b0;
    first_at = '0;
  endfunction

  // advances the search state by one transaction; returns 1 with the report on an end
  function automatic bit search_step(item_t it, output result_t res);
    bit hit;
    int unsigned s;
    res = '0;
    case (it.opcode)
      OP_CLEAR: begin
        pat_len = 0;
        forget_text();
      end
      OP_APPEND: begin
        if (pat_len < PATTERN_MAX) begin
          pat_bytes[pat_len] = it.char_in;
          pat_len++;
        end
      end
      OP_TEXT: begin
        for (int i = PATTERN_MAX - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = it.char_in;
        if (text_seen != '1) text_seen++;
        if (!match_latched && pat_len > 0 && text_seen >= pat_len) begin
          hit = 1'b1;
          for (int j = 0; j < pat_len; j++) begin
            if (pat_bytes[j] != window[pat_len-1-j]) hit = 1'b0;
          end
          if (hit) begin
            s = text_seen - pat_len;
            match_latched = 1'b1;
            first_at = (s > 32'hFFFF) ? 16'hFFFF : s[15:0];
          end
        end
      end
      default: begin
        if (pat_len == 0) begin
          res.found = (text_seen != 0);
        end else begin
          res.found = match_latched;
          res.match_start = match_latched ? first_at : 16'h0000;
        end
        forget_text();
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic send(item_t it, bit typed = 1'b0, result_t want = '0);
    result_t res;
    bit go;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do begin
      @(negedge clk);
      go = !item_stall;
      @(posedge clk);
    end while (!go);
    if (!(it.opcode == OP_APPEND && pat_len == PATTERN_MAX)) useful_items++;
    if (search_step(it, res)) begin
      pending_reports.push_back(typed ? want : res);
      ends_issued++;
    end
  endtask

  // one search: mostly well-formed with random content, sometimes noise
  task automatic random_search();
    logic [7:0] sym_a;
    logic [7:0] sym_b;
    int plen;
    int tlen;
    int roll;
    logic [31:0] r;
    sym_a = rand_byte();
    sym_b = ($urandom_range(9) == 0) ? sym_a : rand_byte();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        r = $urandom;
        send(mk(r[9:8], r[7:0]));
      end
      return;
    end
    if ($urandom_range(9) != 0) send(mk(OP_CLEAR, rand_byte()));
    roll = $urandom_range(99);
    if (roll < 10) plen = 0;
    else if (roll < 20) plen = $urandom_range(17, 20);
    else if (roll < 50) plen = $urandom_range(7, 16);
    else plen = $urandom_range(1, 6);
    repeat (plen) send(mk(OP_APPEND, $urandom_range(1) ? sym_a : sym_b));
    tlen = $urandom_range(0, 30);
    repeat (tlen) begin
      roll = $urandom_range(99);
      if (roll < 3) send(mk(OP_CLEAR, rand_byte()));
      else if (roll < 7) send(mk(OP_APPEND, $urandom_range(1) ? sym_a : sym_b));
      send(mk(OP_TEXT, (roll >= 90) ? rand_byte() : ($urandom_range(1) ? sym_a : sym_b)));
    end
    send(mk(OP_END, rand_byte()));
  endtask

  // result side: random stall, plus a long hold-off on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(negedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch("unexpected result, found", result.found, 0);
      end else begin
        want = pending_reports.pop_front();
        if (result.found != want.found)
          flag_mismatch("found", result.found, want.found);
        if (result.match_start != want.match_start)
          flag_mismatch("match_start", result.match_start, want.match_start);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(negedge clk);
      if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t watchdog: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
    $display("testbench: errors");
    $finish;
  end

  initial begin
    int idle_mix [4];
    int stall_mix [4];
    int item_goal;
    int end_goal;
    idle_mix = '{0, 86, 0, 36};
    stall_mix = '{0, 0, 86, 36};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      repeat (plan[r].reps) send(plan[r].it, plan[r].typed, plan[r].want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_mix[ph];
      recv_stall_pct = stall_mix[ph];
      item_goal = useful_items + 75;
      end_goal = ends_issued + 3;
      while (useful_items < item_goal || ends_issued < end_goal) random_search();
    end

    // back-pressure: results held off while ends keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_token++;
    repeat (24) begin
      send(mk(OP_TEXT, rand_byte()));
      send(mk(OP_END, rand_byte()));
    end
    item_valid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
